// ----- src/prime_count_above_threshold_core_defines.svh -----
// Assertion macros shared by the prime count RTL.
// Each macro samples on clk and is disabled while rst is high.
`ifndef PRIME_COUNT_ABOVE_THRESHOLD_CORE_DEFINES_SVH
`define PRIME_COUNT_ABOVE_THRESHOLD_CORE_DEFINES_SVH

// Same-cycle implication.
`define PCAT_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("pcat assertion failed");

// Next-cycle implication.
`define PCAT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("pcat assertion failed");

`endif

// ----- src/pcat_pkg.sv -----
// Shared types and constants for the prime count block.
// Used by pcat_div, pcat_ctrl, pcat_dp and the top level; no dependencies.
package pcat_pkg;

  localparam int VALUE_W   = 32;
  localparam int CNT_W     = 11;
  localparam int DIVD_W    = 31;  // dividend: positive values only reach the divider
  localparam int DIVR_W    = 16;  // divisors stay below 46350
  localparam int SQ_W      = 2 * DIVR_W;
  localparam int DIV_STEPS = (DIVD_W + 1) / 2;  // two quotient bits per cycle
  localparam int STEP_W    = $clog2(DIV_STEPS);

  localparam logic [CNT_W-1:0]  MAX_ITEMS  = CNT_W'(1024);
  localparam logic [DIVR_W-1:0] BASE_INIT  = DIVR_W'(5);
  localparam logic [DIVR_W-1:0] BASE_INCR  = DIVR_W'(6);
  localparam logic [DIVR_W-1:0] PAIR_OFFS  = DIVR_W'(2);
  localparam logic [DIVR_W-1:0] DIV_THREE  = DIVR_W'(3);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CLASSIFY,
    ST_WAIT3,
    ST_SQ,
    ST_CMP,
    ST_WAIT_LO,
    ST_WAIT_HI,
    ST_DONE
  } state_t;

  typedef enum logic [1:0] {
    DSRC_THREE,
    DSRC_BASE,
    DSRC_BASE2
  } div_src_t;

  typedef struct packed {
    logic     load;        // take a new item
    logic     div_start;   // launch a remainder
    div_src_t div_src;
    logic     init_base;   // base = 5
    logic     sq_load;     // sq = base * base
    logic     base_step;   // base += 6
    logic     verdict_we;
    logic     verdict;     // 1 = prime
    logic     commit;      // write result register and update count
  } cmd_t;

  typedef struct packed {
    logic le1;
    logic le3;
    logic even;
    logic div_done;
    logic rem_zero;
    logic sq_gt;
    logic out_free;
  } status_t;

endpackage

// ----- src/pcat_div.sv -----
// Iterative remainder unit: 31-bit dividend by 16-bit divisor, two bits a cycle.
// Depends on pcat_pkg.
module pcat_div (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [pcat_pkg::DIVD_W-1:0]  dividend,
  input  logic [pcat_pkg::DIVR_W-1:0]  divisor,
  output logic                         busy,
  output logic                         done,
  output logic                         rem_zero
);

  logic [2*pcat_pkg::DIV_STEPS-1:0] sh;
  logic [pcat_pkg::DIVR_W-1:0]      rem;
  logic [pcat_pkg::DIVR_W-1:0]      dvs;
  logic [pcat_pkg::STEP_W-1:0]      cnt;
  logic [pcat_pkg::DIVR_W-1:0]      rem_next;

  always_comb begin
    logic [pcat_pkg::DIVR_W:0]   t1;
    logic [pcat_pkg::DIVR_W:0]   t2;
    logic [pcat_pkg::DIVR_W-1:0] r1;
    t1 = {rem, sh[2*pcat_pkg::DIV_STEPS-1]};
    if (t1 >= {1'b0, dvs}) begin
      t1 = t1 - {1'b0, dvs};
    end
    r1 = t1[pcat_pkg::DIVR_W-1:0];
    t2 = {r1, sh[2*pcat_pkg::DIV_STEPS-2]};
    if (t2 >= {1'b0, dvs}) begin
      t2 = t2 - {1'b0, dvs};
    end
    rem_next = t2[pcat_pkg::DIVR_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      done <= 1'b0;
      cnt  <= '0;
    end else if (busy) begin
      cnt <= cnt + pcat_pkg::STEP_W'(1);
      if (cnt == pcat_pkg::STEP_W'(pcat_pkg::DIV_STEPS - 1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end else begin
      done <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      sh  <= (2*pcat_pkg::DIV_STEPS)'(dividend);
      rem <= '0;
      dvs <= divisor;
    end else if (busy) begin
      sh  <= sh << 2;
      rem <= rem_next;
    end
  end

  assign rem_zero = (rem == '0);

endmodule

// ----- src/pcat_ctrl.sv -----
// Sequencer for the trial division: classify, test by 3, then 6k-1 / 6k+1 pairs.
// Depends on pcat_pkg; drives pcat_dp through cmd_t and reads status_t.
module pcat_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               item_valid,
  output logic               item_ready,
  input  pcat_pkg::status_t  status,
  output pcat_pkg::cmd_t     cmd
);

  pcat_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pcat_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      pcat_pkg::ST_IDLE: begin
        if (item_valid) state_next = pcat_pkg::ST_CLASSIFY;
      end
      pcat_pkg::ST_CLASSIFY: begin
        if (status.le1 || status.le3 || status.even) begin
          state_next = pcat_pkg::ST_DONE;
        end else begin
          state_next = pcat_pkg::ST_WAIT3;
        end
      end
      pcat_pkg::ST_WAIT3: begin
        if (status.div_done) begin
          state_next = status.rem_zero ? pcat_pkg::ST_DONE : pcat_pkg::ST_SQ;
        end
      end
      pcat_pkg::ST_SQ: state_next = pcat_pkg::ST_CMP;
      pcat_pkg::ST_CMP: begin
        state_next = status.sq_gt ? pcat_pkg::ST_DONE : pcat_pkg::ST_WAIT_LO;
      end
      pcat_pkg::ST_WAIT_LO: begin
        if (status.div_done) begin
          state_next = status.rem_zero ? pcat_pkg::ST_DONE : pcat_pkg::ST_WAIT_HI;
        end
      end
      pcat_pkg::ST_WAIT_HI: begin
        if (status.div_done) begin
          state_next = status.rem_zero ? pcat_pkg::ST_DONE : pcat_pkg::ST_SQ;
        end
      end
      pcat_pkg::ST_DONE: begin
        if (status.out_free) state_next = pcat_pkg::ST_IDLE;
      end
      default: state_next = pcat_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd        = '0;
    cmd.div_src = pcat_pkg::DSRC_THREE;
    item_ready = 1'b0;
    case (state)
      pcat_pkg::ST_IDLE: begin
        item_ready = 1'b1;
        cmd.load   = item_valid;
      end
      pcat_pkg::ST_CLASSIFY: begin
        // two and three are prime, other evens and anything below two are not
        if (status.le1) begin
          cmd.verdict_we = 1'b1;
        end else if (status.le3) begin
          cmd.verdict_we = 1'b1;
          cmd.verdict    = 1'b1;
        end else if (status.even) begin
          cmd.verdict_we = 1'b1;
        end else begin
          cmd.div_start = 1'b1;
          cmd.init_base = 1'b1;
        end
      end
      pcat_pkg::ST_WAIT3: begin
        cmd.verdict_we = status.div_done && status.rem_zero;
      end
      pcat_pkg::ST_SQ: cmd.sq_load = 1'b1;
      pcat_pkg::ST_CMP: begin
        if (status.sq_gt) begin
          cmd.verdict_we = 1'b1;
          cmd.verdict    = 1'b1;
        end else begin
          cmd.div_start = 1'b1;
          cmd.div_src   = pcat_pkg::DSRC_BASE;
        end
      end
      pcat_pkg::ST_WAIT_LO: begin
        if (status.div_done) begin
          if (status.rem_zero) begin
            cmd.verdict_we = 1'b1;
          end else begin
            cmd.div_start = 1'b1;
            cmd.div_src   = pcat_pkg::DSRC_BASE2;
          end
        end
      end
      pcat_pkg::ST_WAIT_HI: begin
        if (status.div_done) begin
          cmd.verdict_we = status.rem_zero;
          cmd.base_step  = !status.rem_zero;
        end
      end
      pcat_pkg::ST_DONE: cmd.commit = status.out_free;
      default: ;
    endcase
  end

endmodule

// ----- src/pcat_dp.sv -----
// Datapath: item and threshold registers, divisor base and square, remainder
// unit, batch counter and result register. Depends on pcat_pkg, pcat_div and
// prime_count_above_threshold_core_defines.svh.
`include "prime_count_above_threshold_core_defines.svh"

module pcat_dp (
  input  logic                                clk,
  input  logic                                rst,
  input  pcat_pkg::cmd_t                      cmd,
  output pcat_pkg::status_t                   status,
  input  logic signed [pcat_pkg::VALUE_W-1:0] value,
  input  logic                                last,
  input  logic                                threshold_we,
  input  logic signed [pcat_pkg::VALUE_W-1:0] threshold,
  output logic                                result_valid,
  input  logic                                result_ready,
  output logic                                qualifies,
  output logic [pcat_pkg::CNT_W-1:0]          running_count,
  output logic                                last_out
);

  logic signed [pcat_pkg::VALUE_W-1:0] value_r;
  logic                                last_r;
  logic signed [pcat_pkg::VALUE_W-1:0] thresh;
  logic [pcat_pkg::DIVR_W-1:0]         base;
  logic [pcat_pkg::SQ_W-1:0]           sq;
  logic                                verdict;
  logic [pcat_pkg::CNT_W-1:0]          count;
  logic [pcat_pkg::DIVR_W-1:0]         divisor;
  logic                                div_busy;
  logic                                div_done;
  logic                                rem_zero;
  logic                                q;
  logic [pcat_pkg::CNT_W-1:0]          count_next;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      value_r <= value;
      last_r  <= last;
    end
    if (cmd.init_base) begin
      base <= pcat_pkg::BASE_INIT;
    end else if (cmd.base_step) begin
      base <= base + pcat_pkg::BASE_INCR;
    end
    if (cmd.sq_load) sq <= base * base;
    if (cmd.verdict_we) verdict <= cmd.verdict;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      thresh <= '0;
    end else if (threshold_we) begin
      thresh <= threshold;
    end
  end

  always_comb begin
    case (cmd.div_src)
      pcat_pkg::DSRC_BASE:  divisor = base;
      pcat_pkg::DSRC_BASE2: divisor = base + pcat_pkg::PAIR_OFFS;
      default:              divisor = pcat_pkg::DIV_THREE;
    endcase
  end

  pcat_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (value_r[pcat_pkg::DIVD_W-1:0]),
    .divisor  (divisor),
    .busy     (div_busy),
    .done     (div_done),
    .rem_zero (rem_zero)
  );

  assign status.le1      = (value_r <= 32'sd1);
  assign status.le3      = (value_r <= 32'sd3);
  assign status.even     = ~value_r[0];
  assign status.div_done = div_done;
  assign status.rem_zero = rem_zero;
  assign status.sq_gt    = (sq > pcat_pkg::SQ_W'(value_r));
  assign status.out_free = !result_valid || result_ready;

  // saturate at the batch limit
  assign q          = verdict && (value_r > thresh);
  assign count_next = (q && count < pcat_pkg::MAX_ITEMS) ?
                      count + pcat_pkg::CNT_W'(1) : count;

  always_ff @(posedge clk) begin
    if (rst) begin
      count        <= '0;
      result_valid <= 1'b0;
    end else if (cmd.commit) begin
      count        <= last_r ? '0 : count_next;
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      qualifies     <= q;
      running_count <= count_next;
      last_out      <= last_r;
    end
  end

  `PCAT_ASSERT_NOW(a_commit_free, cmd.commit, !result_valid || result_ready)
  `PCAT_ASSERT_NOW(a_count_limit, 1'b1, count <= pcat_pkg::MAX_ITEMS)
  `PCAT_ASSERT_NEXT(a_batch_clear, cmd.commit && last_r, count == '0)
  `PCAT_ASSERT_NOW(a_div_idle, cmd.div_start, !div_busy && !cmd.commit)

endmodule

// ----- src/prime_count_above_threshold_core.sv -----
// Prime count above threshold: one item in flight, tested by trial division.
// Values below 5 or even are decided at classification without division; others
// are tested by three, then by 6k-1 / 6k+1 divisor pairs (two remainders per
// pair) until the square of the base exceeds the value or a remainder is zero.
// Throughput: the next item is taken once the result is in the output register.
// Reset (rst, synchronous): threshold 0, batch count 0, no result pending.
module prime_count_above_threshold_core (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                item_valid,
  output logic                                item_ready,
  input  logic signed [pcat_pkg::VALUE_W-1:0] value,
  input  logic                                last,
  input  logic                                threshold_we,
  input  logic signed [pcat_pkg::VALUE_W-1:0] threshold,
  output logic                                result_valid,
  input  logic                                result_ready,
  output logic                                qualifies,
  output logic [pcat_pkg::CNT_W-1:0]          running_count,
  output logic                                last_out
);

  pcat_pkg::cmd_t    cmd;
  pcat_pkg::status_t status;

  pcat_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .status     (status),
    .cmd        (cmd)
  );

  pcat_dp u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .status        (status),
    .value         (value),
    .last          (last),
    .threshold_we  (threshold_we),
    .threshold     (threshold),
    .result_valid  (result_valid),
    .result_ready  (result_ready),
    .qualifies     (qualifies),
    .running_count (running_count),
    .last_out      (last_out)
  );

endmodule
